// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the edge-list text parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/elp_pkg.sv =====
// ----------------------------------------------------------------------------
// elp_pkg
// Shared types and constants of the edge-list text parser.
// ----------------------------------------------------------------------------
package elp_pkg;

  // Width of a vertex number; larger magnitudes are rejected.
  localparam int VERTEX_BITS = 32;

  // Depth of the queue between classifier and parser.
  localparam int QUEUE_DEPTH = 4;

  // Byte classes handed from the front end to the parser.
  typedef enum logic [3:0] {
    CLS_DIGIT,
    CLS_PLUS,
    CLS_MINUS,
    CLS_NEWLINE,
    CLS_BLANK,       // space or tab
    CLS_SPACE_CTRL,  // vertical tab, form feed, carriage return
    CLS_HASH,
    CLS_NUL,
    CLS_END,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
  } token_t;

  typedef struct packed {
    logic   avail;
    token_t tok;
  } qhead_t;

  typedef enum logic [3:0] {
    PH_LINE_START,
    PH_SKIP,
    PH_SRC_PRE,
    PH_SRC_SIGN,
    PH_SRC_DIG,
    PH_TGT_PRE,
    PH_TGT_SIGN,
    PH_TGT_DIG,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_EDGE       = 2'd0,
    KIND_BAD_SOURCE = 2'd1,
    KIND_BAD_TARGET = 2'd2,
    KIND_SUMMARY    = 2'd3
  } kind_t;

endpackage

// ===== rtl/elp_front.sv =====
// ----------------------------------------------------------------------------
// elp_front
// Input handshake and byte classification into queue words.
// ----------------------------------------------------------------------------
module elp_front (
  input  logic            byte_valid,
  input  logic [7:0]      ch,
  input  logic            stream_end,
  input  logic            q_full,
  output logic            byte_stall,
  output logic            push,
  output elp_pkg::token_t tok
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;

  assign byte_stall = q_full;
  assign push       = byte_valid && !q_full;

  always_comb begin
    tok.digit = 4'(ch - CH_DIGIT0);
    if (stream_end) begin
      tok.cls = elp_pkg::CLS_END;
    end else begin
      unique case (ch) inside
        [CH_DIGIT0:CH_DIGIT9]:   tok.cls = elp_pkg::CLS_DIGIT;
        CH_PLUS:                 tok.cls = elp_pkg::CLS_PLUS;
        CH_MINUS:                tok.cls = elp_pkg::CLS_MINUS;
        CH_LF:                   tok.cls = elp_pkg::CLS_NEWLINE;
        CH_SPACE, CH_TAB:        tok.cls = elp_pkg::CLS_BLANK;
        CH_VT, CH_FF, CH_CR:     tok.cls = elp_pkg::CLS_SPACE_CTRL;
        CH_HASH:                 tok.cls = elp_pkg::CLS_HASH;
        CH_NUL:                  tok.cls = elp_pkg::CLS_NUL;
        default:                 tok.cls = elp_pkg::CLS_OTHER;
      endcase
    end
  end

endmodule

// ===== rtl/elp_queue.sv =====
// ----------------------------------------------------------------------------
// elp_queue
// Short word queue that decouples the classifier from the parser.
// ----------------------------------------------------------------------------
module elp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  elp_pkg::token_t wr_tok,
  input  logic            pop,
  output logic            full,
  output elp_pkg::qhead_t head
);

  localparam int PTR_BITS   = (elp_pkg::QUEUE_DEPTH > 1) ? $clog2(elp_pkg::QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(elp_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0]   LAST_SLOT = PTR_BITS'(elp_pkg::QUEUE_DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] FULL_CNT  = COUNT_BITS'(elp_pkg::QUEUE_DEPTH);

  elp_pkg::token_t        entries [elp_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr;
  logic [PTR_BITS-1:0]    rd_ptr;
  logic [COUNT_BITS-1:0]  count;

  assign full       = (count == FULL_CNT);
  assign head.avail = (count != '0);
  assign head.tok   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + COUNT_BITS'(1);
        2'b01:   count <= count - COUNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/elp_back.sv =====
// ----------------------------------------------------------------------------
// elp_back
// Line parser: phase machine, decimal accumulator, edge count, result register.
// ----------------------------------------------------------------------------
module elp_back (
  input  logic            clk,
  input  logic            rst,
  input  elp_pkg::qhead_t head,
  output logic            pop,
  input  logic            result_stall,
  output logic            result_valid,
  output logic [1:0]      kind,
  output logic [31:0]     source_vertex,
  output logic [31:0]     target_vertex,
  output logic [63:0]     edge_number,
  output logic            last_of_run
);

  localparam int VB       = elp_pkg::VERTEX_BITS;
  localparam int MAC_BITS = VB + 4;

  elp_pkg::phase_t phase, phase_next;
  logic [VB-1:0]   acc;
  logic            too_large;
  logic            minus_seen;
  logic [VB-1:0]   held_source;
  logic [63:0]     edge_total;

  elp_pkg::cls_t   cls;
  logic            fire;
  logic            num_ok;
  logic [MAC_BITS-1:0] mac_wide;
  logic            mac_over;
  logic [63:0]     total_inc;

  logic            emit;
  elp_pkg::kind_t  emit_kind;
  logic            emit_last;
  logic            hold_tok;
  logic            do_mac;
  logic            set_sign;
  logic            do_clear;
  logic            load_src;
  logic            count_edge;

  assign cls       = head.tok.cls;
  assign fire      = head.avail && (!result_valid || !result_stall);
  assign pop       = fire && !hold_tok;
  assign num_ok    = !too_large && !(minus_seen && (acc != '0));
  assign mac_wide  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + MAC_BITS'(head.tok.digit);
  assign mac_over  = (mac_wide[MAC_BITS-1:VB] != '0);
  assign total_inc = edge_total + 64'd1;

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      elp_pkg::PH_LINE_START: begin
        unique case (cls) inside
          elp_pkg::CLS_DIGIT:                      phase_next = elp_pkg::PH_SRC_DIG;
          elp_pkg::CLS_PLUS, elp_pkg::CLS_MINUS:   phase_next = elp_pkg::PH_SRC_SIGN;
          elp_pkg::CLS_SPACE_CTRL:                 phase_next = elp_pkg::PH_SRC_PRE;
          elp_pkg::CLS_HASH, elp_pkg::CLS_NUL:     phase_next = elp_pkg::PH_SKIP;
          elp_pkg::CLS_BLANK, elp_pkg::CLS_NEWLINE: phase_next = elp_pkg::PH_LINE_START;
          default:                                 phase_next = elp_pkg::PH_HALT;
        endcase
      end
      elp_pkg::PH_SKIP: begin
        unique case (cls) inside
          elp_pkg::CLS_NEWLINE: phase_next = elp_pkg::PH_LINE_START;
          elp_pkg::CLS_END:     phase_next = elp_pkg::PH_HALT;
          default:              phase_next = elp_pkg::PH_SKIP;
        endcase
      end
      elp_pkg::PH_SRC_PRE, elp_pkg::PH_TGT_PRE: begin
        unique case (cls) inside
          elp_pkg::CLS_DIGIT:
            phase_next = (phase == elp_pkg::PH_SRC_PRE) ? elp_pkg::PH_SRC_DIG
                                                         : elp_pkg::PH_TGT_DIG;
          elp_pkg::CLS_PLUS, elp_pkg::CLS_MINUS:
            phase_next = (phase == elp_pkg::PH_SRC_PRE) ? elp_pkg::PH_SRC_SIGN
                                                         : elp_pkg::PH_TGT_SIGN;
          elp_pkg::CLS_BLANK, elp_pkg::CLS_SPACE_CTRL:
            phase_next = phase;
          default:
            phase_next = elp_pkg::PH_HALT;
        endcase
      end
      elp_pkg::PH_SRC_SIGN, elp_pkg::PH_TGT_SIGN: begin
        if (cls == elp_pkg::CLS_DIGIT) begin
          phase_next = (phase == elp_pkg::PH_SRC_SIGN) ? elp_pkg::PH_SRC_DIG
                                                        : elp_pkg::PH_TGT_DIG;
        end else begin
          phase_next = elp_pkg::PH_HALT;
        end
      end
      elp_pkg::PH_SRC_DIG: begin
        if (cls == elp_pkg::CLS_DIGIT) begin
          phase_next = elp_pkg::PH_SRC_DIG;
        end else if (!num_ok) begin
          phase_next = elp_pkg::PH_HALT;
        end else begin
          unique case (cls) inside
            elp_pkg::CLS_BLANK, elp_pkg::CLS_SPACE_CTRL: phase_next = elp_pkg::PH_TGT_PRE;
            elp_pkg::CLS_PLUS, elp_pkg::CLS_MINUS:       phase_next = elp_pkg::PH_TGT_SIGN;
            default:                                     phase_next = elp_pkg::PH_HALT;
          endcase
        end
      end
      elp_pkg::PH_TGT_DIG: begin
        if (cls == elp_pkg::CLS_DIGIT) begin
          phase_next = elp_pkg::PH_TGT_DIG;
        end else if (!num_ok) begin
          phase_next = elp_pkg::PH_HALT;
        end else if (cls == elp_pkg::CLS_NEWLINE) begin
          phase_next = elp_pkg::PH_LINE_START;
        end else begin
          phase_next = elp_pkg::PH_SKIP;
        end
      end
      default: phase_next = elp_pkg::PH_HALT;
    endcase
  end

  // Actions and results for the word at the queue head.
  always_comb begin
    emit       = 1'b0;
    emit_kind  = elp_pkg::KIND_EDGE;
    emit_last  = 1'b1;
    hold_tok   = 1'b0;
    do_mac     = 1'b0;
    set_sign   = 1'b0;
    do_clear   = 1'b0;
    load_src   = 1'b0;
    count_edge = 1'b0;
    unique case (phase)
      elp_pkg::PH_LINE_START: begin
        unique case (cls) inside
          elp_pkg::CLS_DIGIT:                    do_mac   = 1'b1;
          elp_pkg::CLS_PLUS, elp_pkg::CLS_MINUS: set_sign = 1'b1;
          elp_pkg::CLS_END: begin
            emit      = 1'b1;
            emit_kind = elp_pkg::KIND_SUMMARY;
          end
          elp_pkg::CLS_OTHER: begin
            emit      = 1'b1;
            emit_kind = elp_pkg::KIND_BAD_SOURCE;
          end
          default: ;
        endcase
      end
      elp_pkg::PH_SKIP: begin
        if (cls == elp_pkg::CLS_END) begin
          emit      = 1'b1;
          emit_kind = elp_pkg::KIND_SUMMARY;
        end
      end
      elp_pkg::PH_SRC_PRE, elp_pkg::PH_TGT_PRE: begin
        unique case (cls) inside
          elp_pkg::CLS_DIGIT:                          do_mac   = 1'b1;
          elp_pkg::CLS_PLUS, elp_pkg::CLS_MINUS:       set_sign = 1'b1;
          elp_pkg::CLS_BLANK, elp_pkg::CLS_SPACE_CTRL: ;
          default: begin
            emit      = 1'b1;
            emit_kind = (phase == elp_pkg::PH_SRC_PRE) ? elp_pkg::KIND_BAD_SOURCE
                                                        : elp_pkg::KIND_BAD_TARGET;
          end
        endcase
      end
      elp_pkg::PH_SRC_SIGN, elp_pkg::PH_TGT_SIGN: begin
        if (cls == elp_pkg::CLS_DIGIT) begin
          do_mac = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_kind = (phase == elp_pkg::PH_SRC_SIGN) ? elp_pkg::KIND_BAD_SOURCE
                                                       : elp_pkg::KIND_BAD_TARGET;
        end
      end
      elp_pkg::PH_SRC_DIG: begin
        if (cls == elp_pkg::CLS_DIGIT) begin
          do_mac = 1'b1;
        end else if (!num_ok) begin
          emit      = 1'b1;
          emit_kind = elp_pkg::KIND_BAD_SOURCE;
        end else begin
          load_src = 1'b1;
          do_clear = 1'b1;
          unique case (cls) inside
            elp_pkg::CLS_BLANK, elp_pkg::CLS_SPACE_CTRL: ;
            elp_pkg::CLS_PLUS, elp_pkg::CLS_MINUS:       set_sign = 1'b1;
            default: begin
              emit      = 1'b1;
              emit_kind = elp_pkg::KIND_BAD_TARGET;
            end
          endcase
        end
      end
      elp_pkg::PH_TGT_DIG: begin
        if (cls == elp_pkg::CLS_DIGIT) begin
          do_mac = 1'b1;
        end else if (!num_ok) begin
          emit      = 1'b1;
          emit_kind = elp_pkg::KIND_BAD_TARGET;
        end else begin
          emit       = 1'b1;
          emit_kind  = elp_pkg::KIND_EDGE;
          count_edge = 1'b1;
          do_clear   = 1'b1;
          // End marker right after a target: edge now, summary on replay.
          if (cls == elp_pkg::CLS_END) begin
            emit_last = 1'b0;
            hold_tok  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= elp_pkg::PH_LINE_START;
      acc         <= '0;
      too_large   <= 1'b0;
      minus_seen  <= 1'b0;
      held_source <= '0;
      edge_total  <= '0;
    end else if (fire) begin
      phase <= phase_next;
      if (do_clear) begin
        acc       <= '0;
        too_large <= 1'b0;
      end else if (do_mac && !too_large) begin
        if (mac_over) begin
          too_large <= 1'b1;
        end else begin
          acc <= mac_wide[VB-1:0];
        end
      end
      if (set_sign) begin
        minus_seen <= (cls == elp_pkg::CLS_MINUS);
      end else if (do_clear) begin
        minus_seen <= 1'b0;
      end
      if (load_src) begin
        held_source <= acc;
      end
      if (count_edge) begin
        edge_total <= total_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      kind          <= emit_kind;
      last_of_run   <= emit_last;
      source_vertex <= (emit_kind == elp_pkg::KIND_EDGE) ? 32'(held_source) : '0;
      target_vertex <= (emit_kind == elp_pkg::KIND_EDGE) ? 32'(acc) : '0;
      edge_number   <= (emit_kind == elp_pkg::KIND_SUMMARY) ? edge_total : total_inc;
    end
  end

endmodule

// ===== rtl/edge_list_text_parser.sv =====
// ----------------------------------------------------------------------------
// edge_list_text_parser
// Turns an edge-list text stream, one byte per word, into binary edges.
//
// Each line "<source> <target> ..." yields one edge result carrying both
// vertex numbers and the running edge count; leading spaces and tabs are
// skipped, empty lines and '#'- or NUL-led lines are dropped, and the rest
// of a line after the target is ignored. A missing, over-range or negative
// nonzero number yields one error result (edge count plus one) and the
// block then swallows every further word without output until reset. A word
// with stream_end set completes a pending target and gives a summary with
// the total (a line cut short before its target gives an error instead);
// after it the block is likewise silent until reset. The input takes one
// word per clock while the queue is not full: a classifier writes a
// four-word queue, and the parser drains one queued word per clock into a
// single result register, so the sustained rate is one word per cycle
// whenever results are taken as fast as they appear. The one exception is
// an end marker right after a complete target, which the parser handles
// twice (edge, then summary). byte_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module edge_list_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  ch,
  input  logic        stream_end,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [31:0] source_vertex,
  output logic [31:0] target_vertex,
  output logic [63:0] edge_number,
  output logic        last_of_run
);

  // Front end to queue
  logic            q_push;
  logic            q_full;
  elp_pkg::token_t q_wr_tok;

  // Queue to parser
  elp_pkg::qhead_t q_head;
  logic            q_pop;

  // Classify the incoming byte; stall only on a full queue.
  elp_front u_front (
    .byte_valid (byte_valid),
    .ch         (ch),
    .stream_end (stream_end),
    .q_full     (q_full),
    .byte_stall (byte_stall),
    .push       (q_push),
    .tok        (q_wr_tok)
  );

  // Hold classified words until the parser is free.
  elp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_tok (q_wr_tok),
    .pop    (q_pop),
    .full   (q_full),
    .head   (q_head)
  );

  // Parse one word per cycle unless results stall; drive the result port.
  elp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .pop           (q_pop),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .kind          (kind),
    .source_vertex (source_vertex),
    .target_vertex (target_vertex),
    .edge_number   (edge_number),
    .last_of_run   (last_of_run)
  );

endmodule

// ===== rtl/elp_checker.sv =====
// ----------------------------------------------------------------------------
// elp_checker
// Port-level assertions for the edge-list text parser, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  kind,
  input logic [63:0] edge_number,
  input logic        last_of_run
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_valid_held, clk, rst, result_valid && result_stall, result_valid)

  // A stalled result keeps its edge number and kind.
  `ASSERT_NEXT(a_payload_held, clk, rst, result_valid && result_stall, $stable(edge_number) && $stable(kind))

  // Errors and the summary always close the run of their word.
  `ASSERT_IMPLY(a_final_is_last, clk, rst, result_valid && (kind != elp_pkg::KIND_EDGE), last_of_run)

  // Nothing follows an error or a summary.
  `ASSERT_NEXT(a_quiet_after_end, clk, rst, result_valid && !result_stall && (kind != elp_pkg::KIND_EDGE), !result_valid)

endmodule

bind edge_list_text_parser elp_checker u_elp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .kind         (kind),
  .edge_number  (edge_number),
  .last_of_run  (last_of_run)
);

// ===== test/edge_list_text_parser_test.sv =====
// ----------------------------------------------------------------------------
// edge_list_text_parser_test
// Feeds edge-list text through the parser and checks every result word
// against a cycle-free model of the line grammar kept in a scoreboard.
// A short directed run covers range extremes, signs, comments and stray
// bytes. Random well-formed lines follow, and the run closes with one
// randomly chosen ending: an end marker or a malformed line. Both
// handshakes idle in random bursts.
// ----------------------------------------------------------------------------
package elp_check_pkg;
  import elp_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  class edge_list_scoreboard;
    localparam logic [8:0] END_MARK = 9'h100;

    typedef struct {
      kind_t       kind;
      logic [31:0] source;
      logic [31:0] target;
      logic [63:0] count;
      logic        is_last;
    } edge_record_t;

    phase_t       phase;
    logic [31:0]  acc;
    logic         too_large;
    logic         minus_seen;
    logic         digit_seen;
    logic [31:0]  held_source;
    logic [63:0]  edge_total;
    edge_record_t predicted_records[$];
    int unsigned  failures;
    int unsigned  records_checked;
    int unsigned  edges_checked;

    function new();
      phase = PH_LINE_START;
      clear_number();
      held_source = '0;
      edge_total = '0;
      failures = 0;
      records_checked = 0;
      edges_checked = 0;
    endfunction

    function void clear_number();
      acc = '0;
      too_large = 1'b0;
      minus_seen = 1'b0;
      digit_seen = 1'b0;
    endfunction

    function void emit(kind_t kind, logic [31:0] src, logic [31:0] tgt, logic [63:0] count);
      edge_record_t rec;
      rec.kind = kind;
      rec.source = src;
      rec.target = tgt;
      rec.count = count;
      rec.is_last = 1'b0;
      predicted_records.push_back(rec);
    endfunction

    function void halt_on_error(kind_t kind);
      emit(kind, '0, '0, edge_total + 64'd1);
      phase = PH_HALT;
    endfunction

    // One byte (or the end marker) through the line grammar. A byte that
    // closes a source number is examined again in the next phase.
    function void consume(logic [8:0] code);
      logic        again;
      logic        is_digit;
      logic        from_source;
      logic [63:0] wide;
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        is_digit = (code >= {1'b0, CH_ZERO}) && (code <= {1'b0, CH_NINE});
        case (phase)
          PH_LINE_START: begin
            if (code == CH_HASH || code == CH_NUL) begin
              phase = PH_SKIP;
            end else if (!(code == CH_SPACE || code == CH_TAB || code == CH_LF ||
                           code == END_MARK)) begin
              clear_number();
              phase = PH_SRC_PRE;
              again = 1'b1;
            end
          end
          PH_SKIP: begin
            if (code == CH_LF) phase = PH_LINE_START;
          end
          PH_SRC_PRE, PH_TGT_PRE: begin
            from_source = (phase == PH_SRC_PRE);
            if (code == CH_PLUS || code == CH_MINUS) begin
              minus_seen = (code == CH_MINUS);
              phase = from_source ? PH_SRC_SIGN : PH_TGT_SIGN;
            end else if (is_digit) begin
              phase = from_source ? PH_SRC_DIG : PH_TGT_DIG;
              again = 1'b1;
            end else if (!(code == CH_SPACE || code == CH_TAB || code == CH_VT ||
                           code == CH_FF || code == CH_CR)) begin
              halt_on_error(from_source ? KIND_BAD_SOURCE : KIND_BAD_TARGET);
            end
          end
          PH_SRC_SIGN, PH_TGT_SIGN: begin
            from_source = (phase == PH_SRC_SIGN);
            if (is_digit) begin
              phase = from_source ? PH_SRC_DIG : PH_TGT_DIG;
              again = 1'b1;
            end else begin
              halt_on_error(from_source ? KIND_BAD_SOURCE : KIND_BAD_TARGET);
            end
          end
          PH_SRC_DIG, PH_TGT_DIG: begin
            from_source = (phase == PH_SRC_DIG);
            if (is_digit) begin
              digit_seen = 1'b1;
              if (!too_large) begin
                wide = {32'd0, acc} * 64'd10 + {60'd0, code[3:0]};
                if (wide > 64'h0000_0000_FFFF_FFFF) too_large = 1'b1;
                else acc = wide[31:0];
              end
            end else if (!digit_seen || too_large || (minus_seen && acc != '0)) begin
              halt_on_error(from_source ? KIND_BAD_SOURCE : KIND_BAD_TARGET);
            end else if (from_source) begin
              held_source = acc;
              clear_number();
              phase = PH_TGT_PRE;
              again = 1'b1;
            end else begin
              edge_total = edge_total + 64'd1;
              emit(KIND_EDGE, held_source, acc, edge_total);
              clear_number();
              phase = (code == CH_LF) ? PH_LINE_START : PH_SKIP;
            end
          end
          default: ;
        endcase
      end
    endfunction

    function void note_word(logic [7:0] c, logic at_end);
      int unsigned queued;
      if (phase == PH_HALT) return;
      queued = predicted_records.size();
      if (at_end) begin
        consume(END_MARK);
        if (phase != PH_HALT) begin
          emit(KIND_SUMMARY, '0, '0, edge_total);
          phase = PH_HALT;
        end
      end else begin
        consume({1'b0, c});
      end
      if (predicted_records.size() > queued)
        predicted_records[predicted_records.size() - 1].is_last = 1'b1;
    endfunction

    task report(string msg);
      failures++;
      $display("ERROR: %s", msg);
    endtask

    task check_record(logic [1:0] kind, logic [31:0] src, logic [31:0] tgt,
                      logic [63:0] count, logic is_last);
      edge_record_t want;
      records_checked++;
      if (predicted_records.size() == 0) begin
        report($sformatf("unexpected result: kind %0d src %0d tgt %0d count %0d last %0b",
                         kind, src, tgt, count, is_last));
        return;
      end
      want = predicted_records.pop_front();
      if (want.kind == KIND_EDGE) edges_checked++;
      if (kind !== want.kind || src !== want.source || tgt !== want.target ||
          count !== want.count || is_last !== want.is_last)
        report($sformatf({"result %0d: got kind %0d src %0d tgt %0d count %0d last %0b,",
                          " want kind %0d src %0d tgt %0d count %0d last %0b"},
                         records_checked, kind, src, tgt, count, is_last,
                         want.kind, want.source, want.target, want.count, want.is_last));
    endtask

    task flush_leftovers();
      edge_record_t want;
      while (predicted_records.size() != 0) begin
        want = predicted_records.pop_front();
        report($sformatf("missing result: kind %0d src %0d tgt %0d count %0d",
                         want.kind, want.source, want.target, want.count));
      end
    endtask
  endclass
endpackage

module edge_list_text_parser_test;
  import elp_pkg::*;
  import elp_check_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1250;  // stop random lines past this
  localparam int unsigned QUIET_FROM   = 1050;  // no idling from here on
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // How the stream is closed. Every ending halts the block until reset, so
  // a run can exercise only one of them; the seed picks which.
  typedef enum int {
    END_AT_LINE_START,
    END_AFTER_EDGE,
    END_IN_SOURCE,
    END_IN_COMMENT,
    BAD_SOURCE_CHAR,
    BAD_SOURCE_HUGE,
    BAD_SOURCE_NEGATIVE,
    BAD_SOURCE_SIGN_ONLY,
    BAD_TARGET_MISSING,
    BAD_TARGET_HUGE,
    BAD_TARGET_NEGATIVE
  } finale_t;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  ch;
  logic        stream_end;
  logic        result_valid;
  logic        result_stall;
  logic [1:0]  kind;
  logic [31:0] source_vertex;
  logic [31:0] target_vertex;
  logic [63:0] edge_number;
  logic        last_of_run;

  edge_list_scoreboard sb;
  int unsigned         words_sent;
  bit                  in_idle_on;
  bit                  out_stall_on;

  edge_list_text_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .ch            (ch),
    .stream_end    (stream_end),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .source_vertex (source_vertex),
    .target_vertex (target_vertex),
    .edge_number   (edge_number),
    .last_of_run   (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("edge_list_text_parser test failed");
    $finish;
  end

  // Result side: stall in bursts while stalling is enabled.
  // Drive once per rising edge so the stall is stable for the whole cycle.
  initial begin : result_stall_gen
    int unsigned stall_left;
    stall_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) stall_left--;
      else if (out_stall_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 5);
      result_stall <= (stall_left > 0);
    end
  end

  // Sample at the falling edge: valid and stall are settled, and a word seen
  // here is taken at the next rising edge.
  always @(negedge clk) begin
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0)
      sb.check_record(kind, source_vertex, target_vertex, edge_number, last_of_run);
  end

  // Present one word and hold it until the block takes it. Called right after
  // a rising edge; returns right after the edge that accepted the word.
  task automatic send_word(input logic [7:0] c, input logic at_end);
    logic accepted;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      // idle: drop valid and scramble the payload, it must be ignored
      byte_valid <= 1'b0;
      ch <= 8'($urandom);
      stream_end <= 1'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    ch <= c;
    stream_end <= at_end;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = (byte_stall === 1'b0);
      if (accepted) sb.note_word(c, at_end);
      @(posedge clk);
    end
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Decimal digits, sometimes behind a few leading zeros.
  task automatic send_number(input logic [63:0] value);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) send_word(CH_ZERO, 1'b0);
    send_text($sformatf("%0d", value));
  endtask

  function automatic logic [31:0] pick_vertex();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 9);
      1:       return $urandom_range(0, 999);
      2:       return $urandom;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'hFFFF_FFFF - $urandom_range(1, 9);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  function automatic logic [7:0] pick_skip_space();
    case ($urandom_range(0, 4))
      0:       return CH_TAB;
      1:       return CH_VT;
      2:       return CH_FF;
      3:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // Sign in front of a vertex: a minus only on a zero magnitude. NUL = none.
  function automatic logic [7:0] pick_sign(input logic [31:0] value);
    case ($urandom_range(0, 5))
      0:       return CH_PLUS;
      1:       return (value == 0) ? CH_MINUS : CH_NUL;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] pick_non_newline();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_LF);
    return b;
  endfunction

  task automatic send_edge_line();
    logic [31:0] src;
    logic [31:0] tgt;
    logic [7:0]  src_sign;
    logic [7:0]  tgt_sign;
    logic [7:0]  closer;
    src = pick_vertex();
    tgt = pick_vertex();
    src_sign = pick_sign(src);
    tgt_sign = pick_sign(tgt);
    repeat ($urandom_range(0, 2)) send_word(pick_skip_space(), 1'b0);
    if (src_sign != CH_NUL) send_word(src_sign, 1'b0);
    send_number(src);
    // a signed target may follow the source with no space between
    if (tgt_sign == CH_NUL || $urandom_range(0, 2) != 0)
      repeat ($urandom_range(1, 3)) send_word(pick_skip_space(), 1'b0);
    if (tgt_sign != CH_NUL) send_word(tgt_sign, 1'b0);
    send_number(tgt);
    if ($urandom_range(0, 1) == 0) begin
      send_word(CH_LF, 1'b0);
    end else begin
      // any non-digit closes the target; the rest of the line is dropped
      do closer = 8'($urandom); while (closer >= CH_ZERO && closer <= CH_NINE);
      send_word(closer, 1'b0);
      if (closer != CH_LF) begin
        repeat ($urandom_range(0, 6)) send_word(pick_non_newline(), 1'b0);
        send_word(CH_LF, 1'b0);
      end
    end
  endtask

  task automatic send_comment_line();
    repeat ($urandom_range(0, 2)) send_word($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
    send_word($urandom_range(0, 3) == 0 ? CH_NUL : CH_HASH, 1'b0);
    repeat ($urandom_range(0, 8)) send_word(pick_non_newline(), 1'b0);
    send_word(CH_LF, 1'b0);
  endtask

  task automatic send_empty_line();
    repeat ($urandom_range(0, 2)) send_word($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
    send_word(CH_LF, 1'b0);
  endtask

  initial begin : stimulus
    finale_t finale;
    sb = new();
    words_sent = 0;
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    rst <= 1'b1;
    byte_valid <= 1'b0;
    ch <= '0;
    stream_end <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: largest vertex behind a vertical tab, signed zero targets,
    // a NUL-led line, a bare comment, an empty line, a sign right after the
    // source and a high-bit byte closing the target.
    send_word(CH_VT, 1'b0);
    send_text("4294967295");
    send_word(CH_TAB, 1'b0);
    send_text("+0\n");
    send_word(CH_NUL, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_LF, 1'b0);
    send_text("#\n\n0-0");
    send_word(8'hA0, 1'b0);
    send_word(CH_LF, 1'b0);

    // Random: mostly well-formed edge lines, with comment and empty lines
    // as noise. Flip idling on and off now and then to get quiet stretches.
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent >= QUIET_FROM) begin
        in_idle_on = 1'b0;
        out_stall_on = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        in_idle_on = 1'($urandom_range(0, 3) != 0);
        out_stall_on = 1'($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 9))
        0:       send_comment_line();
        1:       send_empty_line();
        default: send_edge_line();
      endcase
    end

    // Close the stream; every choice leaves the block halted.
    finale = finale_t'($urandom_range(0, int'(BAD_TARGET_NEGATIVE)));
    case (finale)
      END_AT_LINE_START: send_word(8'($urandom), 1'b1);
      END_AFTER_EDGE: begin
        send_number(pick_vertex());
        send_word(CH_SPACE, 1'b0);
        send_number(pick_vertex());
        send_word(8'($urandom), 1'b1);
      end
      END_IN_SOURCE: begin
        send_number(pick_vertex());
        send_word(8'($urandom), 1'b1);
      end
      END_IN_COMMENT: begin
        send_text("# no edge here");
        send_word(8'($urandom), 1'b1);
      end
      BAD_SOURCE_CHAR: send_text("x 5\n");
      BAD_SOURCE_HUGE: begin
        send_number(64'h1_0000_0000 + 64'($urandom_range(0, 1000)));
        send_text(" 1\n");
      end
      BAD_SOURCE_NEGATIVE: begin
        send_word(CH_MINUS, 1'b0);
        send_number(64'($urandom_range(1, 999)));
        send_text(" 2\n");
      end
      BAD_SOURCE_SIGN_ONLY: send_text("+ 2\n");
      BAD_TARGET_MISSING: begin
        send_number(pick_vertex());
        send_word(CH_LF, 1'b0);
      end
      BAD_TARGET_HUGE: begin
        send_number(pick_vertex());
        send_word(CH_TAB, 1'b0);
        send_number({32'($urandom_range(1, 9)), 32'($urandom)});
        send_word(CH_LF, 1'b0);
      end
      default: begin
        send_number(pick_vertex());
        send_word(CH_SPACE, 1'b0);
        send_word(CH_MINUS, 1'b0);
        send_number(64'($urandom_range(1, 999)));
        send_word(CH_LF, 1'b0);
      end
    endcase

    // Halted: further words, end markers included, must give nothing.
    repeat (4) send_word(8'($urandom), 1'($urandom));
    send_text("1 2\n");
    byte_valid <= 1'b0;

    // Drain what is still owed, then watch for strays.
    while (sb.predicted_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flush_leftovers();

    $display("Sent %0d text words; checked %0d results, %0d of them edges.",
             words_sent, sb.records_checked, sb.edges_checked);
    $display("Stream closed by %s; %0d mismatches.", finale.name(), sb.failures);
    if (sb.failures == 0) begin
      $display("edge_list_text_parser test passed");
    end else begin
      $display("edge_list_text_parser test failed");
    end
    $finish;
  end

endmodule

// ===== edge_list_text_parser.f =====
+incdir+rtl
rtl/elp_pkg.sv
rtl/elp_front.sv
rtl/elp_queue.sv
rtl/elp_back.sv
rtl/edge_list_text_parser.sv
rtl/elp_checker.sv
test/edge_list_text_parser_test.sv
